>>> sv/nrw_pkg.sv
// nrw_pkg: shared types and constants for the name registry block.
// No dependencies.
package nrw_pkg;

    localparam logic [1:0] KIND_REG_OK    = 2'd0;
    localparam logic [1:0] KIND_REG_NOSPC = 2'd1;
    localparam logic [1:0] KIND_LOOKUP    = 2'd2;

    localparam logic ACT_REGISTER = 1'b0;
    localparam logic ACT_LOOKUP   = 1'b1;

    localparam logic [5:0] NULL_LINK = 6'd63;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SEARCH = 9'b000000010,
        ST_DECIDE = 9'b000000100,
        ST_REPLY  = 9'b000001000,
        ST_WRD    = 9'b000010000,
        ST_WOUT   = 9'b000100000,
        ST_FREE   = 9'b001000000,
        ST_POP    = 9'b010000000,
        ST_PUSH   = 9'b100000000
    } state_t;

endpackage

>>> sv/nrw_ram.sv
// nrw_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
module nrw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/name_registry_with_waiters_top.sv
// name_registry_with_waiters_top: keyed name registry with per-name wait stacks.
// Depends on nrw_pkg and nrw_ram.
//
// Usage:
//   Input channel (in_valid/in_stall) carries action, name_key, client_id.
//   Output channel (out_valid/out_stall) carries dest_task, reply_kind,
//   found_task and last; last marks the final reply of one request.
//   One request is handled at a time; in_stall stays high until it is done.
//   Records are searched one per cycle (key RAM read is registered), and a
//   register request then releases its waiters one reply at a time. A
//   register request for a new name on a full table answers no-space; a
//   lookup of a new name on a full table, or of an unowned name with an
//   empty waiter pool, gives no reply. Waiters are answered newest first.
//   Reset empties the table and links the waiter pool; no clearing pass.
//   When the receiver stalls, the reply holds in the output register and
//   the sequencer waits there; a new request waits before its decision
//   until the previous reply has been taken.
module name_registry_with_waiters_top #(
    parameter int TASKS      = 32,
    parameter int NAMES      = 32,
    parameter int NAME_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [63:0] name_key,
    input  logic [4:0]  client_id,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  dest_task,
    output logic [1:0]  reply_kind,
    output logic [4:0]  found_task,
    output logic        last
);

    localparam int RW = (NAMES > 1) ? $clog2(NAMES) : 1;
    localparam int TW = $clog2(TASKS);
    localparam int CW = $clog2(NAMES + 1);
    localparam logic [63:0] KEY_MASK = (NAME_BYTES >= 8) ? {64{1'b1}}
        : ((64'd1 << (8 * NAME_BYTES)) - 64'd1);

    nrw_pkg::state_t state_reg, state_next;

    logic          act_reg;
    logic [63:0]   key_reg;
    logic [4:0]    cid_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [5:0]    free_reg, free_next;
    logic [5:0]    head_reg, head_next;
    logic [TW:0]   guard_reg, guard_next;
    logic          cmp_pend_reg;
    logic          hit_reg;
    logic [TASKS-1:0] lnk_init_reg;

    logic          ov_reg;
    logic [4:0]    od_reg, of_reg;
    logic [1:0]    ok_reg;
    logic          ol_reg;

    // RAM ports
    logic [RW-1:0] rec_raddr, rec_waddr;
    logic [63:0]   key_rd;
    logic          key_we;
    logic [11:0]   info_rd, info_wd;   // {known, owner[4:0], head[5:0]}
    logic          info_we;
    logic [TW-1:0] node_raddr, node_waddr;
    logic [10:0]   node_rd, node_wd;   // {task[4:0], link[5:0]}
    logic          node_we;
    logic [TW-1:0] node_rd_addr_reg;

    nrw_ram #(.WIDTH(64), .DEPTH(NAMES)) u_key (
        .clk(clk), .we(key_we), .waddr(rec_waddr), .wdata(key_reg),
        .raddr(rec_raddr), .rdata(key_rd));
    nrw_ram #(.WIDTH(12), .DEPTH(NAMES)) u_info (
        .clk(clk), .we(info_we), .waddr(rec_waddr), .wdata(info_wd),
        .raddr(rec_raddr), .rdata(info_rd));
    nrw_ram #(.WIDTH(11), .DEPTH(TASKS)) u_node (
        .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wd),
        .raddr(node_raddr), .rdata(node_rd));

    // Node links not yet written read as their reset value.
    logic [5:0] link_rd;
    always_comb
    begin
        if (!lnk_init_reg[node_rd_addr_reg])
        begin
            link_rd = (32'(node_rd_addr_reg) + 1 < TASKS)
                ? 6'(node_rd_addr_reg + 1'b1) : nrw_pkg::NULL_LINK;
        end
        else
        begin
            link_rd = node_rd[5:0];
        end
    end

    logic out_free;
    assign out_free = !ov_reg || !out_stall;
    assign in_stall = (state_reg != nrw_pkg::ST_IDLE);
    logic in_xfer;
    assign in_xfer = in_valid && !in_stall;
    logic [RW-1:0] rec_sel;
    assign rec_sel = idx_reg[RW-1:0];

    logic       load_out;
    logic [4:0] ld_d, ld_f;
    logic [1:0] ld_k;
    logic       ld_l;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        free_next  = free_reg;
        head_next  = head_reg;
        guard_next = guard_reg;
        rec_raddr  = rec_sel;
        rec_waddr  = rec_sel;
        key_we     = 1'b0;
        info_we    = 1'b0;
        info_wd    = info_rd;
        node_raddr = head_reg[TW-1:0];
        node_waddr = head_reg[TW-1:0];
        node_we    = 1'b0;
        node_wd    = '0;
        load_out   = 1'b0;
        ld_d = cid_reg; ld_k = nrw_pkg::KIND_REG_OK; ld_f = '0; ld_l = 1'b0;
        unique case (state_reg)
            nrw_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    idx_next   = '0;
                    state_next = nrw_pkg::ST_SEARCH;
                end
            end
            nrw_pkg::ST_SEARCH:
            begin
                // Compare sees the registered key read of the record at idx_reg - 1.
                if (cmp_pend_reg && key_rd == key_reg)
                begin
                    state_next = nrw_pkg::ST_DECIDE;
                end
                else if (idx_reg >= count_reg)
                begin
                    state_next = nrw_pkg::ST_DECIDE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (cmp_pend_reg && key_rd == key_reg)
                begin
                    idx_next = idx_reg - 1'b1;
                    rec_raddr = RW'(idx_reg - 1'b1);
                end
            end
            nrw_pkg::ST_DECIDE:
            begin
                // Hold here while the previous request's last reply is stalled.
                if (out_free)
                begin
                    if (!hit_reg && count_reg >= CW'(NAMES))
                    begin
                        if (act_reg == nrw_pkg::ACT_REGISTER)
                        begin
                            ld_k = nrw_pkg::KIND_REG_NOSPC;
                            ld_l = 1'b1;
                            state_next = nrw_pkg::ST_REPLY;
                        end
                        else
                        begin
                            state_next = nrw_pkg::ST_IDLE;
                        end
                    end
                    else if (act_reg == nrw_pkg::ACT_REGISTER)
                    begin
                        key_we  = !hit_reg;
                        info_we = 1'b1;
                        info_wd = {1'b1, cid_reg, nrw_pkg::NULL_LINK};
                        if (!hit_reg)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        head_next  = hit_reg ? info_rd[5:0] : nrw_pkg::NULL_LINK;
                        guard_next = '0;
                        ld_k = nrw_pkg::KIND_REG_OK;
                        ld_l = !hit_reg || !(32'(info_rd[5:0]) < TASKS);
                        state_next = nrw_pkg::ST_REPLY;
                    end
                    else if (hit_reg && info_rd[11])
                    begin
                        ld_k = nrw_pkg::KIND_LOOKUP;
                        ld_f = info_rd[10:6];
                        ld_l = 1'b1;
                        state_next = nrw_pkg::ST_REPLY;
                    end
                    else
                    begin
                        if (!hit_reg)
                        begin
                            key_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                            info_wd    = {1'b0, 5'd0, nrw_pkg::NULL_LINK};
                        end
                        head_next = hit_reg ? info_rd[5:0] : nrw_pkg::NULL_LINK;
                        if (32'(free_reg) < TASKS)
                        begin
                            info_we    = !hit_reg;
                            node_raddr = free_reg[TW-1:0];
                            state_next = nrw_pkg::ST_POP;
                        end
                        else
                        begin
                            info_we    = !hit_reg;
                            free_next  = nrw_pkg::NULL_LINK;
                            state_next = nrw_pkg::ST_IDLE;
                        end
                    end
                    load_out = (state_next == nrw_pkg::ST_REPLY);
                end
            end
            nrw_pkg::ST_POP:
            begin
                // Take node free_reg, push it on the record's stack.
                free_next  = link_rd;
                node_we    = 1'b1;
                node_waddr = free_reg[TW-1:0];
                node_wd    = {cid_reg, head_reg};
                head_next  = free_reg;
                state_next = nrw_pkg::ST_PUSH;
            end
            nrw_pkg::ST_PUSH:
            begin
                info_we    = 1'b1;
                info_wd    = {1'b0, 5'd0, head_reg};
                state_next = nrw_pkg::ST_IDLE;
            end
            nrw_pkg::ST_REPLY:
            begin
                if (out_free)
                begin
                    if (ok_reg == nrw_pkg::KIND_REG_OK && !ol_reg)
                    begin
                        node_raddr = head_reg[TW-1:0];
                        state_next = nrw_pkg::ST_WRD;
                    end
                    else
                    begin
                        state_next = nrw_pkg::ST_IDLE;
                    end
                end
            end
            nrw_pkg::ST_WRD:
            begin
                state_next = nrw_pkg::ST_WOUT;
            end
            nrw_pkg::ST_WOUT:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    ld_d = node_rd[10:6];
                    ld_k = nrw_pkg::KIND_LOOKUP;
                    ld_f = cid_reg;
                    ld_l = !(32'(link_rd) < TASKS) || (32'(guard_reg) + 1 >= TASKS);
                    node_we    = 1'b1;
                    node_waddr = head_reg[TW-1:0];
                    node_wd    = {node_rd[10:6], free_reg};
                    free_next  = head_reg;
                    head_next  = link_rd;
                    guard_next = guard_reg + 1'b1;
                    state_next = ld_l ? nrw_pkg::ST_IDLE : nrw_pkg::ST_FREE;
                end
            end
            nrw_pkg::ST_FREE:
            begin
                node_raddr = head_reg[TW-1:0];
                state_next = nrw_pkg::ST_WRD;
            end
            default:
            begin
                state_next = nrw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= nrw_pkg::ST_IDLE;
            count_reg    <= '0;
            free_reg     <= '0;
            cmp_pend_reg <= 1'b0;
            hit_reg      <= 1'b0;
            lnk_init_reg <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            free_reg  <= free_next;
            cmp_pend_reg <= (state_reg == nrw_pkg::ST_SEARCH)
                && (state_next == nrw_pkg::ST_SEARCH);
            if (state_reg == nrw_pkg::ST_IDLE)
            begin
                hit_reg <= 1'b0;
            end
            else if (state_reg == nrw_pkg::ST_SEARCH && cmp_pend_reg
                && key_rd == key_reg)
            begin
                hit_reg <= 1'b1;
            end
            if (node_we)
            begin
                lnk_init_reg[node_waddr] <= 1'b1;
            end
            if (load_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        head_reg  <= head_next;
        guard_reg <= guard_next;
        node_rd_addr_reg <= node_raddr;
        if (in_xfer)
        begin
            act_reg <= action;
            key_reg <= name_key & KEY_MASK;
            cid_reg <= client_id;
        end
        if (load_out)
        begin
            od_reg <= ld_d;
            ok_reg <= ld_k;
            of_reg <= ld_f;
            ol_reg <= ld_l;
        end
    end

    assign out_valid  = ov_reg;
    assign dest_task  = od_reg;
    assign reply_kind = ok_reg;
    assign found_task = of_reg;
    assign last       = ol_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(NAMES)) else $error("record count overflow");
    a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == nrw_pkg::ST_SEARCH) else $error("accept lost");
    a_nospc_last: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && ok_reg == nrw_pkg::KIND_REG_NOSPC |-> ol_reg)
        else $error("no-space reply not final");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> count_reg == $past(count_reg) + 1'b1)
        else $error("count jumped");
`endif

endmodule
